### rtl/rnc_pkg.sv
// Shared types, constants and lookup functions for the Roman numeral codec.
// No dependencies; imported by every module of the codec.
package rnc_pkg;

   localparam int SumWidthDefault = 16;
   localparam int QueueDepth      = 2;
   localparam int NumberWidth     = 12;
   localparam int TotalWidth      = 16;
   localparam int SymbolWidth     = 8;
   localparam int ValueWidth      = 11;
   localparam int StepIdxWidth    = 4;

   localparam logic [NumberWidth-1:0] MaxNumber = 12'd3999;

   localparam logic OPC_ENCODE = 1'b0;
   localparam logic OPC_CHAR   = 1'b1;

   localparam logic KIND_CHAR  = 1'b0;
   localparam logic KIND_VALUE = 1'b1;

   localparam logic [2:0] RANK_NONE = 3'd7;

   localparam logic [SymbolWidth-1:0] CHR_NONE = 8'h00;
   localparam logic [SymbolWidth-1:0] CHR_I    = 8'h49;
   localparam logic [SymbolWidth-1:0] CHR_V    = 8'h56;
   localparam logic [SymbolWidth-1:0] CHR_X    = 8'h58;
   localparam logic [SymbolWidth-1:0] CHR_L    = 8'h4C;
   localparam logic [SymbolWidth-1:0] CHR_C    = 8'h43;
   localparam logic [SymbolWidth-1:0] CHR_D    = 8'h44;
   localparam logic [SymbolWidth-1:0] CHR_M    = 8'h4D;

   typedef enum logic [1:0] {
      OP_ENCODE,
      OP_ZERO,
      OP_RANGE,
      OP_TOTAL
   } entry_op_type;

   // One job handed from front to back: a number to spell out or a decoded total.
   typedef struct packed {
      entry_op_type           op;
      logic [TotalWidth-1:0]  data;
   } entry_type;

   typedef struct packed {
      logic [NumberWidth-1:0] value;
      logic [SymbolWidth-1:0] first;
      logic [SymbolWidth-1:0] second;
      logic                   pair;
   } greedy_step_type;

   function automatic logic [2:0] rank_of(input logic [SymbolWidth-1:0] ch);
      logic [2:0] r;
      case (ch)
         CHR_I:   r = 3'd0;
         CHR_V:   r = 3'd1;
         CHR_X:   r = 3'd2;
         CHR_L:   r = 3'd3;
         CHR_C:   r = 3'd4;
         CHR_D:   r = 3'd5;
         CHR_M:   r = 3'd6;
         default: r = RANK_NONE;
      endcase
      return r;
   endfunction

   function automatic logic [ValueWidth-1:0] value_of(input logic [2:0] r);
      logic [ValueWidth-1:0] v;
      case (r)
         3'd0:    v = 11'd1;
         3'd1:    v = 11'd5;
         3'd2:    v = 11'd10;
         3'd3:    v = 11'd50;
         3'd4:    v = 11'd100;
         3'd5:    v = 11'd500;
         3'd6:    v = 11'd1000;
         default: v = '0;
      endcase
      return v;
   endfunction

   // Unknown characters order below I.
   function automatic logic [2:0] order_key(input logic [2:0] r);
      return (r == RANK_NONE) ? 3'd0 : r + 3'd1;
   endfunction

   // Greedy table, largest first, subtractive pairs included.
   function automatic greedy_step_type greedy_step(input logic [StepIdxWidth-1:0] idx);
      greedy_step_type s;
      case (idx)
         4'd0:    s = '{12'd1000, CHR_M, CHR_NONE, 1'b0};
         4'd1:    s = '{12'd900,  CHR_C, CHR_M,    1'b1};
         4'd2:    s = '{12'd500,  CHR_D, CHR_NONE, 1'b0};
         4'd3:    s = '{12'd400,  CHR_C, CHR_D,    1'b1};
         4'd4:    s = '{12'd100,  CHR_C, CHR_NONE, 1'b0};
         4'd5:    s = '{12'd90,   CHR_X, CHR_C,    1'b1};
         4'd6:    s = '{12'd50,   CHR_L, CHR_NONE, 1'b0};
         4'd7:    s = '{12'd40,   CHR_X, CHR_L,    1'b1};
         4'd8:    s = '{12'd10,   CHR_X, CHR_NONE, 1'b0};
         4'd9:    s = '{12'd9,    CHR_I, CHR_X,    1'b1};
         4'd10:   s = '{12'd5,    CHR_V, CHR_NONE, 1'b0};
         4'd11:   s = '{12'd4,    CHR_I, CHR_V,    1'b1};
         4'd12:   s = '{12'd1,    CHR_I, CHR_NONE, 1'b0};
         default: s = '{12'd1,    CHR_I, CHR_NONE, 1'b0};
      endcase
      return s;
   endfunction

endpackage

### rtl/rnc_front.sv
// Front end: accepts items, keeps the numeral decode state, classifies jobs.
// Depends on rnc_pkg.
module rnc_front
   import rnc_pkg::*;
#(
   parameter int SUM_WIDTH = SumWidthDefault
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  logic                   req_opcode,
   input  logic [NumberWidth-1:0] req_number,
   input  logic [SymbolWidth-1:0] req_symbol,
   input  logic                   req_final_char,
   output logic                   q_push,
   output entry_type              q_entry
);

   logic [2:0]           held_rank_ff, held_rank_in;
   logic                 held_valid_ff, held_valid_in;
   logic [SUM_WIDTH-1:0] sum_ff, sum_in;

   logic [2:0]            rank;
   logic [ValueWidth-1:0] val, held_val;
   logic                  sub;
   logic [SUM_WIDTH:0]    wide;
   logic [SUM_WIDTH-1:0]  sum_new;
   logic [TotalWidth-1:0] total;

   always_comb begin
      rank     = rank_of(req_symbol);
      val      = value_of(rank);
      held_val = value_of(held_rank_ff);
      sub      = held_valid_ff && (order_key(rank) > order_key(held_rank_ff));
      // A higher symbol is worth at least twice the held one, so this never underflows.
      wide     = {1'b0, sum_ff} + (SUM_WIDTH+1)'(val)
                 - (sub ? (SUM_WIDTH+1)'({held_val, 1'b0}) : '0);
      sum_new  = wide[SUM_WIDTH] ? {SUM_WIDTH{1'b1}} : wide[SUM_WIDTH-1:0];
      if (sum_new > SUM_WIDTH'({TotalWidth{1'b1}})) begin
         total = {TotalWidth{1'b1}};
      end else begin
         total = TotalWidth'(sum_new);
      end

      held_rank_in  = held_rank_ff;
      held_valid_in = held_valid_ff;
      sum_in        = sum_ff;
      q_push        = 1'b0;
      q_entry.op    = OP_ENCODE;
      q_entry.data  = TotalWidth'(req_number);

      if (accept) begin
         if (req_opcode == OPC_ENCODE) begin
            q_push = 1'b1;
            if (req_number > MaxNumber) begin
               q_entry.op = OP_RANGE;
            end else if (req_number == '0) begin
               q_entry.op = OP_ZERO;
            end
         end else if (req_final_char) begin
            q_push        = 1'b1;
            q_entry.op    = OP_TOTAL;
            q_entry.data  = total;
            held_rank_in  = RANK_NONE;
            held_valid_in = 1'b0;
            sum_in        = '0;
         end else begin
            held_rank_in  = rank;
            held_valid_in = 1'b1;
            sum_in        = sum_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_rank_ff  <= RANK_NONE;
         held_valid_ff <= 1'b0;
         sum_ff        <= '0;
      end else begin
         held_rank_ff  <= held_rank_in;
         held_valid_ff <= held_valid_in;
         sum_ff        <= sum_in;
      end
   end

endmodule

### rtl/rnc_queue.sv
// Short job queue between front and back ends, built from flops.
// Depends on rnc_pkg.
module rnc_queue
   import rnc_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   input  logic      pop,
   output logic      q_full,
   output logic      q_empty,
   output entry_type head
);

   localparam int PtrWidth = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
   localparam int CntWidth = $clog2(QueueDepth + 1);
   localparam logic [PtrWidth-1:0] LastPtr = PtrWidth'(QueueDepth - 1);
   localparam logic [CntWidth-1:0] FullCnt = CntWidth'(QueueDepth);

   entry_type           slot_ff [QueueDepth];
   logic [PtrWidth-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CntWidth-1:0] count_ff, count_in;
   logic                do_push, do_pop;

   always_comb begin
      q_full    = (count_ff == FullCnt);
      q_empty   = (count_ff == '0);
      head      = slot_ff[rd_ptr_ff];
      do_push   = push && !q_full;
      do_pop    = pop && !q_empty;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

### rtl/rnc_back.sv
// Back end: spells numbers out by walking the greedy table, drives the result register.
// Depends on rnc_pkg.
module rnc_back
   import rnc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   q_empty,
   input  entry_type              q_head,
   output logic                   q_pop,
   input  logic                   pop,
   output logic                   empty,
   output logic                   rsp_kind,
   output logic [SymbolWidth-1:0] rsp_out_char,
   output logic [TotalWidth-1:0]  rsp_total,
   output logic                   rsp_empty_line,
   output logic                   rsp_range_error,
   output logic                   rsp_end_of_run
);

   logic                    busy_ff, busy_in;
   entry_op_type            op_ff, op_in;
   logic [TotalWidth-1:0]   data_ff, data_in;
   logic [StepIdxWidth-1:0] idx_ff, idx_in;
   logic                    second_ff, second_in;

   logic                   out_valid_ff, out_valid_in;
   logic                   kind_ff, kind_in;
   logic [SymbolWidth-1:0] char_ff, char_in;
   logic [TotalWidth-1:0]  total_ff, total_in;
   logic                   empty_line_ff, empty_line_in;
   logic                   range_error_ff, range_error_in;
   logic                   end_ff, end_in;

   logic                   out_free, emit;
   greedy_step_type        step;
   logic [NumberWidth-1:0] rem, diff;

   always_comb begin
      out_free = !out_valid_ff || pop;
      step     = greedy_step(idx_ff);
      rem      = data_ff[NumberWidth-1:0];
      diff     = rem - step.value;

      busy_in   = busy_ff;
      op_in     = op_ff;
      data_in   = data_ff;
      idx_in    = idx_ff;
      second_in = second_ff;
      q_pop     = 1'b0;

      emit           = 1'b0;
      kind_in        = KIND_CHAR;
      char_in        = CHR_NONE;
      total_in       = '0;
      empty_line_in  = 1'b0;
      range_error_in = 1'b0;
      end_in         = 1'b0;

      if (!busy_ff) begin
         if (!q_empty) begin
            q_pop     = 1'b1;
            busy_in   = 1'b1;
            op_in     = q_head.op;
            data_in   = q_head.data;
            idx_in    = '0;
            second_in = 1'b0;
         end
      end else if (out_free) begin
         case (op_ff)
            OP_ZERO: begin
               emit          = 1'b1;
               empty_line_in = 1'b1;
               end_in        = 1'b1;
               busy_in       = 1'b0;
            end
            OP_RANGE: begin
               emit           = 1'b1;
               range_error_in = 1'b1;
               end_in         = 1'b1;
               busy_in        = 1'b0;
            end
            OP_TOTAL: begin
               emit     = 1'b1;
               kind_in  = KIND_VALUE;
               total_in = data_ff;
               end_in   = 1'b1;
               busy_in  = 1'b0;
            end
            OP_ENCODE: begin
               if (second_ff) begin
                  // remainder was already reduced when the pair's first char went out
                  emit      = 1'b1;
                  char_in   = step.second;
                  second_in = 1'b0;
                  end_in    = (rem == '0);
                  busy_in   = (rem != '0);
               end else if (rem >= step.value) begin
                  emit    = 1'b1;
                  char_in = step.first;
                  data_in = TotalWidth'(diff);
                  if (step.pair) begin
                     second_in = 1'b1;
                  end else begin
                     end_in  = (diff == '0);
                     busy_in = (diff != '0);
                  end
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
            default: begin
               busy_in = 1'b0;
            end
         endcase
      end

      if (emit) begin
         out_valid_in = 1'b1;
      end else if (pop) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         second_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         second_ff    <= second_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff   <= op_in;
      data_ff <= data_in;
      idx_ff  <= idx_in;
      if (emit) begin
         kind_ff        <= kind_in;
         char_ff        <= char_in;
         total_ff       <= total_in;
         empty_line_ff  <= empty_line_in;
         range_error_ff <= range_error_in;
         end_ff         <= end_in;
      end
   end

   assign empty           = !out_valid_ff;
   assign rsp_kind        = kind_ff;
   assign rsp_out_char    = char_ff;
   assign rsp_total       = total_ff;
   assign rsp_empty_line  = empty_line_ff;
   assign rsp_range_error = range_error_ff;
   assign rsp_end_of_run  = end_ff;

endmodule

### rtl/roman_numeral_codec_core.sv
// Roman numeral codec, encode and decode directions, front/queue/back structure.
// Depends on rnc_pkg, rnc_front, rnc_queue and rnc_back.
//
// Push number items (opcode 0) or numeral characters (opcode 1, left to right) into
// the request side; results come out of a queue-style response side. A numeral
// character needs no result unless it is marked final, in which case one result
// carries the total (saturating at 65535). An encode of a number N yields one result
// per Roman character, most significant first, with end_of_run on the last; zero and
// values above 3999 yield one flagged result. The back end walks a 13-step greedy
// table (1000, 900, ... 4, 1) from the top, emitting characters while the remainder
// allows and stepping down otherwise; the longest spelling, 3888, has fifteen
// characters. It holds one job at a time, takes the next from the queue only once
// done, and waits while the response side holds off. Decode jobs and flagged encodes
// give their single result without walking the table. A two-entry job queue lets
// characters keep arriving while the back end spells out a number; full rises when
// it fills.
module roman_numeral_codec_core
   import rnc_pkg::*;
#(
   parameter int SUM_WIDTH = SumWidthDefault
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   output logic                   full,
   input  logic                   req_opcode,
   input  logic [NumberWidth-1:0] req_number,
   input  logic [SymbolWidth-1:0] req_symbol,
   input  logic                   req_final_char,
   output logic                   empty,
   input  logic                   pop,
   output logic                   rsp_kind,
   output logic [SymbolWidth-1:0] rsp_out_char,
   output logic [TotalWidth-1:0]  rsp_total,
   output logic                   rsp_empty_line,
   output logic                   rsp_range_error,
   output logic                   rsp_end_of_run
);

   logic      accept;
   logic      q_push, q_pop, q_full, q_empty;
   entry_type q_entry, q_head;

   assign full   = q_full;
   assign accept = push && !q_full;

   rnc_front #(
      .SUM_WIDTH(SUM_WIDTH)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .req_opcode     (req_opcode),
      .req_number     (req_number),
      .req_symbol     (req_symbol),
      .req_final_char (req_final_char),
      .q_push         (q_push),
      .q_entry        (q_entry)
   );

   rnc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .pop        (q_pop),
      .q_full     (q_full),
      .q_empty    (q_empty),
      .head       (q_head)
   );

   rnc_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_empty         (q_empty),
      .q_head          (q_head),
      .q_pop           (q_pop),
      .pop             (pop),
      .empty           (empty),
      .rsp_kind        (rsp_kind),
      .rsp_out_char    (rsp_out_char),
      .rsp_total       (rsp_total),
      .rsp_empty_line  (rsp_empty_line),
      .rsp_range_error (rsp_range_error),
      .rsp_end_of_run  (rsp_end_of_run)
   );

endmodule

### test/tb_roman_numeral_codec_core.sv
// Self-checking testbench for roman_numeral_codec_core: encodes numbers, decodes numerals.
// Depends on rnc_pkg and the codec RTL; the expected results come from a predictor in this file.
module tb_roman_numeral_codec_core
   import rnc_pkg::*;
;

   localparam int SumMax = (1 << SumWidthDefault) - 1;

   typedef struct packed {
      logic                   kind;
      logic [SymbolWidth-1:0] out_char;
      logic [TotalWidth-1:0]  total;
      logic                   empty_line;
      logic                   range_error;
      logic                   end_of_run;
   } rsp_type;

   typedef struct packed {
      logic                   op;
      logic [NumberWidth-1:0] number;
      logic [SymbolWidth-1:0] symbol;
      logic                   fin;
      logic                   has_want;
      rsp_type                want;
   } row_type;

   typedef logic [SymbolWidth-1:0] text_type [$];

   localparam rsp_type NO_RSP  = '0;
   localparam rsp_type R_EMPTY = '{KIND_CHAR, CHR_NONE, 16'd0, 1'b1, 1'b0, 1'b1};
   localparam rsp_type R_RANGE = '{KIND_CHAR, CHR_NONE, 16'd0, 1'b0, 1'b1, 1'b1};

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   push = 1'b0;
   logic                   full;
   logic                   req_opcode = OPC_ENCODE;
   logic [NumberWidth-1:0] req_number = '0;
   logic [SymbolWidth-1:0] req_symbol = '0;
   logic                   req_final_char = 1'b0;
   logic                   empty;
   logic                   pop = 1'b0;
   logic                   rsp_kind;
   logic [SymbolWidth-1:0] rsp_out_char;
   logic [TotalWidth-1:0]  rsp_total;
   logic                   rsp_empty_line;
   logic                   rsp_range_error;
   logic                   rsp_end_of_run;

   // typed-in result that replaces the predicted one for the item being offered
   logic    drv_has_want = 1'b0;
   rsp_type drv_want = '0;

   // decode state of the predictor
   logic [2:0]  dec_rank = RANK_NONE;
   logic        dec_held = 1'b0;
   logic [16:0] dec_sum = '0;

   rsp_type owed[$];
   int   mismatches = 0;
   int   n_sent = 0;
   int   tx_calm = 0;
   int   rx_calm = 0;
   int   rx_gap = 0;
   int   rx_hold = 0;

   row_type directed [25] = '{
      '{OPC_ENCODE, 12'd0,    8'h00, 1'b0, 1'b1, R_EMPTY},
      '{OPC_ENCODE, 12'd4095, 8'hFF, 1'b1, 1'b1, R_RANGE},
      '{OPC_ENCODE, 12'd4000, CHR_M, 1'b0, 1'b1, R_RANGE},
      '{OPC_ENCODE, 12'd1,    8'h00, 1'b0, 1'b1,
        '{KIND_CHAR, CHR_I, 16'd0, 1'b0, 1'b0, 1'b1}},
      '{OPC_ENCODE, 12'd3999, 8'h00, 1'b0, 1'b0, NO_RSP},
      '{OPC_ENCODE, 12'd3888, 8'h00, 1'b0, 1'b0, NO_RSP},
      '{OPC_ENCODE, 12'd2730, 8'h55, 1'b1, 1'b0, NO_RSP},
      '{OPC_ENCODE, 12'd1365, 8'hAA, 1'b0, 1'b0, NO_RSP},
      '{OPC_CHAR,   12'd4095, CHR_M, 1'b1, 1'b1,
        '{KIND_VALUE, CHR_NONE, 16'd1000, 1'b0, 1'b0, 1'b1}},
      '{OPC_CHAR,   12'd0,    8'hFF, 1'b1, 1'b1,
        '{KIND_VALUE, CHR_NONE, 16'd0, 1'b0, 1'b0, 1'b1}},
      '{OPC_CHAR,   12'd0,    CHR_I, 1'b0, 1'b0, NO_RSP},
      '{OPC_CHAR,   12'd0,    CHR_V, 1'b1, 1'b0, NO_RSP},
      '{OPC_CHAR,   12'd0,    CHR_X, 1'b0, 1'b0, NO_RSP},
      '{OPC_CHAR,   12'd0,    CHR_I, 1'b0, 1'b0, NO_RSP},
      '{OPC_CHAR,   12'd0,    CHR_X, 1'b1, 1'b0, NO_RSP},
      // unknown character between two I
      '{OPC_CHAR,   12'd0,    CHR_I, 1'b0, 1'b0, NO_RSP},
      '{OPC_CHAR,   12'd0,    8'h00, 1'b0, 1'b0, NO_RSP},
      '{OPC_CHAR,   12'd0,    CHR_I, 1'b1, 1'b0, NO_RSP},
      // encode in the middle of a numeral leaves the decode state alone
      '{OPC_CHAR,   12'd0,    CHR_C, 1'b0, 1'b0, NO_RSP},
      '{OPC_ENCODE, 12'd1994, CHR_X, 1'b1, 1'b0, NO_RSP},
      '{OPC_CHAR,   12'd0,    CHR_M, 1'b1, 1'b0, NO_RSP},
      '{OPC_CHAR,   12'd0,    CHR_D, 1'b0, 1'b0, NO_RSP},
      '{OPC_CHAR,   12'd0,    CHR_L, 1'b0, 1'b0, NO_RSP},
      '{OPC_CHAR,   12'd0,    CHR_C, 1'b1, 1'b0, NO_RSP},
      '{OPC_CHAR,   12'd0,    CHR_I, 1'b1, 1'b1,
        '{KIND_VALUE, CHR_NONE, 16'd1, 1'b0, 1'b0, 1'b1}}
   };

   roman_numeral_codec_core dut (
      .clock(clock),
      .reset(reset),
      .push(push),
      .full(full),
      .req_opcode(req_opcode),
      .req_number(req_number),
      .req_symbol(req_symbol),
      .req_final_char(req_final_char),
      .empty(empty),
      .pop(pop),
      .rsp_kind(rsp_kind),
      .rsp_out_char(rsp_out_char),
      .rsp_total(rsp_total),
      .rsp_empty_line(rsp_empty_line),
      .rsp_range_error(rsp_range_error),
      .rsp_end_of_run(rsp_end_of_run)
   );

   always #10 clock = ~clock;

   function automatic logic [SymbolWidth-1:0] roman_char(input int r);
      case (r)
         0: return CHR_I;
         1: return CHR_V;
         2: return CHR_X;
         3: return CHR_L;
         4: return CHR_C;
         5: return CHR_D;
         6: return CHR_M;
         default: return CHR_NONE;
      endcase
   endfunction

   function automatic logic [2:0] symbol_rank(input logic [SymbolWidth-1:0] ch);
      case (ch)
         CHR_I: return 3'd0;
         CHR_V: return 3'd1;
         CHR_X: return 3'd2;
         CHR_L: return 3'd3;
         CHR_C: return 3'd4;
         CHR_D: return 3'd5;
         CHR_M: return 3'd6;
         default: return RANK_NONE;
      endcase
   endfunction

   function automatic int rank_worth(input logic [2:0] r);
      case (r)
         3'd0: return 1;
         3'd1: return 5;
         3'd2: return 10;
         3'd3: return 50;
         3'd4: return 100;
         3'd5: return 500;
         3'd6: return 1000;
         default: return 0;
      endcase
   endfunction

   // unknown characters order below I
   function automatic int rank_order(input logic [2:0] r);
      return (r == RANK_NONE) ? 0 : int'(r) + 1;
   endfunction

   // subtractive spelling, thousands digit first
   function automatic text_type roman_text(input int num);
      text_type t;
      int d, p, k, scale;
      logic [SymbolWidth-1:0] one, five, ten;
      scale = 1000;
      for (p = 3; p >= 0; p--) begin
         d = (num / scale) % 10;
         one = roman_char(2 * p);
         five = roman_char(2 * p + 1);
         ten = roman_char(2 * p + 2);
         if (d == 9) begin
            t.push_back(one);
            t.push_back(ten);
         end else if (d >= 5) begin
            t.push_back(five);
            for (k = 5; k < d; k++) t.push_back(one);
         end else if (d == 4) begin
            t.push_back(one);
            t.push_back(five);
         end else begin
            for (k = 0; k < d; k++) t.push_back(one);
         end
         scale = scale / 10;
      end
      return t;
   endfunction

   function automatic string rsp_text(input rsp_type r);
      return $sformatf("kind=%0d char=%02h total=%0d empty_line=%0d range_error=%0d last=%0d",
                       r.kind, r.out_char, r.total, r.empty_line, r.range_error, r.end_of_run);
   endfunction

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic flag_mismatch(input string what);
      $display("mismatch at %0t: %s", $time, what);
      mismatches++;
   endtask

   task automatic spell_number(input logic [NumberWidth-1:0] num);
      text_type t;
      if (num > MaxNumber) begin
         owed.push_back(R_RANGE);
      end else if (num == 0) begin
         owed.push_back(R_EMPTY);
      end else begin
         t = roman_text(int'(num));
         foreach (t[i])
            owed.push_back('{KIND_CHAR, t[i], 16'd0, 1'b0, 1'b0, i == t.size() - 1});
      end
   endtask

   task automatic accumulate_char(input logic [SymbolWidth-1:0] sym, input logic fin);
      logic [2:0] r;
      int s;
      r = symbol_rank(sym);
      s = int'(dec_sum) + rank_worth(r);
      if (dec_held && rank_order(r) > rank_order(dec_rank))
         s = s - 2 * rank_worth(dec_rank);
      if (s > SumMax) s = SumMax;
      dec_sum = s[16:0];
      dec_rank = r;
      dec_held = 1'b1;
      if (fin) begin
         owed.push_back('{KIND_VALUE, CHR_NONE,
                          (dec_sum > 17'd65535) ? 16'hFFFF : dec_sum[15:0],
                          1'b0, 1'b0, 1'b1});
         dec_sum = '0;
         dec_rank = RANK_NONE;
         dec_held = 1'b0;
      end
   endtask

   // predictor on accepted items, checker on accepted results
   always @(posedge clock) begin
      rsp_type got, want;
      if (!reset && push && !full) begin
         if (req_opcode == OPC_ENCODE) spell_number(req_number);
         else accumulate_char(req_symbol, req_final_char);
         if (drv_has_want) begin
            void'(owed.pop_back());
            owed.push_back(drv_want);
         end
      end
      if (!reset && pop && !empty) begin
         got = '{rsp_kind, rsp_out_char, rsp_total, rsp_empty_line, rsp_range_error,
                 rsp_end_of_run};
         if (owed.size() == 0) begin
            flag_mismatch({"result with nothing expected: ", rsp_text(got)});
         end else begin
            want = owed.pop_front();
            if (got !== want)
               flag_mismatch({"got ", rsp_text(got), " expected ", rsp_text(want)});
         end
         if (rx_calm > 0) begin
            rx_calm--;
            rx_gap = 0;
         end else begin
            if ($urandom_range(0, 39) == 0) rx_calm = $urandom_range(20, 60);
            rx_gap = gap_len();
         end
      end
   end

   initial begin : receiver
      forever begin
         @(negedge clock);
         if (reset) begin
            pop <= 1'b0;
         end else if (rx_hold > 0) begin
            pop <= 1'b0;
            rx_hold--;
         end else if (rx_gap > 0) begin
            pop <= 1'b0;
            rx_gap--;
         end else begin
            pop <= 1'b1;
         end
      end
   end

   task automatic pause(input int n);
      if (n > 0) begin
         @(negedge clock);
         push <= 1'b0;
         repeat (n - 1) @(negedge clock);
      end
   endtask

   // offer one item and hold it until the transfer, then idle at random
   task automatic send(input logic op, input logic [NumberWidth-1:0] num,
                       input logic [SymbolWidth-1:0] sym, input logic fin,
                       input logic has_want, input rsp_type want);
      @(negedge clock);
      push <= 1'b1;
      req_opcode <= op;
      req_number <= num;
      req_symbol <= sym;
      req_final_char <= fin;
      drv_has_want <= has_want;
      drv_want <= want;
      do @(posedge clock); while (full);
      n_sent++;
      if (tx_calm > 0) begin
         tx_calm--;
      end else begin
         if ($urandom_range(0, 49) == 0) tx_calm = $urandom_range(20, 60);
         pause(gap_len());
      end
   endtask

   task automatic send_char(input logic [SymbolWidth-1:0] sym, input logic fin);
      send(OPC_CHAR, NumberWidth'($urandom_range(0, 4095)), sym, fin, 1'b0, NO_RSP);
   endtask

   task automatic send_number(input int num);
      send(OPC_ENCODE, NumberWidth'(num), SymbolWidth'($urandom_range(0, 255)),
           1'($urandom_range(0, 1)), 1'b0, NO_RSP);
   endtask

   // stop offering, then wait for every owed result
   task automatic wait_drained();
      @(negedge clock);
      push <= 1'b0;
      while (owed.size() != 0) @(posedge clock);
   endtask

   initial begin : stimulus
      text_type text;
      int pick, value, split, k, len;
      logic [SymbolWidth-1:0] ch;

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed[i])
         send(directed[i].op, directed[i].number, directed[i].symbol, directed[i].fin,
              directed[i].has_want, directed[i].want);

      // sender waits for every result, then the receiver stalls while long encodes pile up
      wait_drained();
      @(posedge clock);
      tx_calm = 1000;
      rx_hold = 250;
      repeat (12) send_number(3888);
      tx_calm = 0;
      wait_drained();

      // a long run of M drives the sum toward saturation; C now and then exercises subtraction at the top
      len = $urandom_range(66, 75);
      for (k = 0; k < len; k++)
         send_char(($urandom_range(0, 9) == 0) ? CHR_C : CHR_M, k == len - 1);

      while (n_sent < 480) begin
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            value = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 60)
                                                 : $urandom_range(1, 3999);
            text = roman_text(value);
            split = ($urandom_range(0, 6) == 0) ? $urandom_range(0, text.size() - 1) : -1;
            foreach (text[i]) begin
               send_char(text[i], i == text.size() - 1);
               if (i == split) send_number($urandom_range(0, 4095));
            end
         end else if (pick < 75) begin
            k = $urandom_range(0, 19);
            if (k == 0) value = 0;
            else if (k == 1) value = $urandom_range(4000, 4095);
            else if (k == 2) value = 3999 - $urandom_range(0, 12);
            else value = $urandom_range(1, 3999);
            send_number(value);
         end else if (pick < 87) begin
            // malformed numeral: a stray, inserted or swapped character
            text = roman_text($urandom_range(1, 3999));
            k = $urandom_range(0, text.size() - 1);
            case ($urandom_range(0, 2))
               0: text[k] = SymbolWidth'($urandom_range(0, 255));
               1: text.insert(k, roman_char($urandom_range(0, 6)));
               default: begin
                  ch = text[k];
                  text[k] = text[0];
                  text[0] = ch;
               end
            endcase
            foreach (text[i]) send_char(text[i], i == text.size() - 1);
         end else begin
            len = $urandom_range(1, 6);
            for (k = 0; k < len; k++) begin
               ch = ($urandom_range(0, 1) == 0) ? roman_char($urandom_range(0, 6))
                                                 : 8'($urandom_range(0, 255));
               send_char(ch, (k == len - 1) ? 1'($urandom_range(0, 1)) : 1'b0);
            end
         end
      end
      // close any numeral left open so its total is checked too
      send_char(roman_char($urandom_range(0, 6)), 1'b1);

      wait_drained();
      repeat (40) @(posedge clock);
      if (mismatches == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end

   initial begin : watchdog
      #30_000_000;
      $display("FAIL");
      $finish;
   end

endmodule

### roman_numeral_codec_core.f
rtl/rnc_pkg.sv
rtl/rnc_front.sv
rtl/rnc_queue.sv
rtl/rnc_back.sv
rtl/roman_numeral_codec_core.sv
test/tb_roman_numeral_codec_core.sv
